// ===== hdl/rrip_pkg.sv =====
// shared types and constants for the rrip replacement policy
package rrip_pkg;

  localparam int unsigned SetsDef       = 2048;
  localparam int unsigned WaysDef       = 16;
  localparam int unsigned SigBitsDef    = 6;
  localparam int unsigned LeaderSetsDef = 32;
  localparam int unsigned DuelWidthDef  = 10;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned PcW    = 18;
  localparam int unsigned SetW   = 11;
  localparam int unsigned WayW   = 4;
  localparam int unsigned PeriodW = 20;
  localparam logic [PeriodW-1:0] PeriodReset = 20'd100000;
  localparam logic [15:0] LfsrReset = 16'hACE1;

  localparam logic KindVictim = 1'b0;
  localparam logic KindUpdate = 1'b1;

  localparam logic [1:0] RrpvNear    = 2'd0;
  localparam logic [1:0] RrpvDistant = 2'd3;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StSig,
    StOut
  } rrip_state_e;

  // one result item
  typedef struct packed {
    logic       bypassed;
    logic [1:0] inserted_rrpv;
    logic [3:0] victim_way;
  } rrip_res_t;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[15:1]};
  endfunction

endpackage

// ===== hdl/rrip_sig_table.sv =====
// signature outcome counters with saturating train and global decay
module rrip_sig_table #(
  parameter int unsigned SigBits = rrip_pkg::SigBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SigBits-1:0] old_sig_i,
  input  logic               inc_i,
  input  logic               dec_i,
  input  logic               decay_i,
  input  logic [SigBits-1:0] new_sig_i,
  output logic               hot_o
);
  import rrip_pkg::*;
  localparam int unsigned Count = 1 << SigBits;

  logic [1:0] ctr_q [Count];
  logic [1:0] ctr_d [Count];

  // hot check sees the value after this item's decrement
  always_comb begin
    logic [1:0] v;
    v = ctr_q[new_sig_i];
    if (dec_i && old_sig_i == new_sig_i && v != 2'd0) v = v - 2'd1;
    hot_o = v[1];
  end

  always_comb begin
    for (int i = 0; i < Count; i++) begin
      ctr_d[i] = ctr_q[i];
      if (SigBits'(i) == old_sig_i) begin
        if (inc_i && ctr_d[i] != 2'd3) ctr_d[i] = ctr_d[i] + 2'd1;
        if (dec_i && ctr_d[i] != 2'd0) ctr_d[i] = ctr_d[i] - 2'd1;
      end
      if (decay_i && ctr_d[i] != 2'd0) ctr_d[i] = ctr_d[i] - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Count; i++) ctr_q[i] <= 2'd1;
    end else begin
      ctr_q <= ctr_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_inc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni) !(inc_i && dec_i))
    else $error("signature counter trained both ways");
  a_decay_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decay_i && !inc_i |=> ctr_q[$past(new_sig_i)] != 2'd3)
    else $error("counter at three after decay");
  a_hot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hot_o |-> ctr_q[new_sig_i] != 2'd0)
    else $error("hot from zero counter");
`endif
endmodule

// ===== hdl/rrip_set_mem.sv =====
// per-set memories: rrpv row, way signatures and stride detector state
module rrip_set_mem #(
  parameter int unsigned Sets    = rrip_pkg::SetsDef,
  parameter int unsigned Ways    = rrip_pkg::WaysDef,
  parameter int unsigned SigBits = rrip_pkg::SigBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(Sets)-1:0]       rd_set_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(Sets)-1:0]       wr_set_i,
  input  logic [2*Ways-1:0]             wr_rrpv_i,
  input  logic [Ways*SigBits-1:0]       wr_sig_i,
  input  logic [1:0]                    wr_conf_i,
  input  logic [rrip_pkg::AddrW-1:0]    wr_addr_i,
  input  logic [rrip_pkg::AddrW-1:0]    wr_stride_i,
  output logic [2*Ways-1:0]             rd_rrpv_o,
  output logic [Ways*SigBits-1:0]       rd_sig_o,
  output logic [1:0]                    rd_conf_o,
  output logic [rrip_pkg::AddrW-1:0]    rd_addr_o,
  output logic [rrip_pkg::AddrW-1:0]    rd_stride_o
);
  import rrip_pkg::*;
  localparam int unsigned RowW = 2*Ways + Ways*SigBits + 2 + 2*AddrW;

  logic [RowW-1:0] mem_q [Sets];
  logic [RowW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_set_i] <= {wr_rrpv_i, wr_sig_i, wr_conf_i, wr_addr_i, wr_stride_i};
    if (rd_en_i) rd_q <= mem_q[rd_set_i];
  end

  assign {rd_rrpv_o, rd_sig_o, rd_conf_o, rd_addr_o, rd_stride_o} = rd_q;
endmodule

// ===== hdl/rrip_ship_stream_dueling_policy.sv =====
// top level of the ship rrip replacement policy with stream detection and set dueling
// steps from accept to result valid: row read, update and write back, output
// a new item is taken only once the last has passed its row read-modify-write; a waiting result
//   stalls the input only once the next result is ready for the output register
// reset: async active low; then a clearing pass sets every row (rrpv three,
//   signatures and stride state zero) before the first item is taken
module rrip_ship_stream_dueling_policy #(
  parameter int unsigned Sets       = rrip_pkg::SetsDef,
  parameter int unsigned Ways       = rrip_pkg::WaysDef,
  parameter int unsigned SigBits    = rrip_pkg::SigBitsDef,
  parameter int unsigned LeaderSets = rrip_pkg::LeaderSetsDef,
  parameter int unsigned DuelWidth  = rrip_pkg::DuelWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: set_index[10:0], way[14:11], address[78:15], pc[96:79], hit[97], zeros
  input  logic [103:0] s_axis_tdata,
  // tuser: kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: victim_way[3:0], inserted_rrpv[5:4], bypassed[6], zero
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [19:0]  cfg_wdata_i
);
  import rrip_pkg::*;

  localparam int unsigned SetBits  = $clog2(Sets);
  localparam int unsigned WayBits  = $clog2(Ways);
  localparam logic [DuelWidth-1:0] DuelMid = DuelWidth'(1) << (DuelWidth-1);
  localparam logic [DuelWidth-1:0] DuelMax = '1;
  // with fewer sets than leaders every set is a bip leader
  localparam bit          AllBip   = Sets < LeaderSets;
  localparam int unsigned BipFirst = AllBip ? 0 : Sets - LeaderSets;

  rrip_state_e state_q, state_d;

  // captured item
  logic               kind_q;
  logic [SetBits-1:0] set_q;
  logic [WayBits-1:0] way_q;
  logic [AddrW-1:0]   addr_q;
  logic [SigBits-1:0] sig_q;
  logic               hit_q;

  logic [SetBits-1:0]   clr_q;
  logic [PeriodW-1:0]   period_q;
  logic [PeriodW-1:0]   tally_q, tally_d;
  logic [DuelWidth-1:0] duel_q, duel_d;
  logic [15:0]          lfsr_q, lfsr_d;
  rrip_res_t            res_q, res_d;
  // output register, keeps a waiting result apart from the work in flight
  rrip_res_t            out_q;
  logic                 ovalid_q;
  logic                 out_free;

  // memory view
  logic [2*Ways-1:0]       rd_rrpv, wr_rrpv;
  logic [Ways*SigBits-1:0] rd_sig, wr_sig;
  logic [1:0]              rd_conf, wr_conf;
  logic [AddrW-1:0]        rd_addr, rd_stride, wr_addr, wr_stride;
  logic                    wr_en;
  logic [SetBits-1:0]      wr_set;

  logic [SigBits-1:0] old_sig;
  logic               sig_inc, sig_dec, sig_decay, hot;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign out_free = !ovalid_q || m_axis_tready;

  // signature fold of the pc
  logic [PcW-1:0] pc_in;
  logic [SigBits-1:0] sig_in;
  assign pc_in  = s_axis_tdata[96:79];
  assign sig_in = SigBits'(pc_in ^ (pc_in >> SigBits) ^ (pc_in >> (2*SigBits)));

  rrip_set_mem #(.Sets(Sets), .Ways(Ways), .SigBits(SigBits)) u_mem (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_set_i   (SetBits'(s_axis_tdata[10:0])),
    .wr_en_i    (wr_en),
    .wr_set_i   (wr_set),
    .wr_rrpv_i  (wr_rrpv),
    .wr_sig_i   (wr_sig),
    .wr_conf_i  (wr_conf),
    .wr_addr_i  (wr_addr),
    .wr_stride_i(wr_stride),
    .rd_rrpv_o  (rd_rrpv),
    .rd_sig_o   (rd_sig),
    .rd_conf_o  (rd_conf),
    .rd_addr_o  (rd_addr),
    .rd_stride_o(rd_stride)
  );

  // registered copies of the row for the second step
  logic [2*Ways-1:0]       row_rrpv_q;
  logic [Ways*SigBits-1:0] row_sig_q;
  logic [1:0]              conf_new_q;
  logic [AddrW-1:0]        stride_new_q;
  logic                    due_q;

  // row state held for writes that leave the stride detector untouched
  logic [1:0]         rd_conf_hold_q;
  logic [AddrW-1:0]   addr_hold_q, stride_hold_q;
  logic [PeriodW-1:0] tally_inc_q;

  // stride detector on the read row
  logic [AddrW-1:0] delta;
  logic [1:0]       conf_new;
  always_comb begin
    delta = (rd_addr == '0) ? '0 : addr_q - rd_addr;
    conf_new = rd_conf;
    if (rd_addr != '0 && delta != '0 && delta == rd_stride) begin
      if (rd_conf != 2'd3) conf_new = rd_conf + 2'd1;
    end else if (rd_conf != 2'd0) begin
      conf_new = rd_conf - 2'd1;
    end
  end

  logic [PeriodW-1:0] tally_inc;
  logic               due;
  assign tally_inc = tally_q + PeriodW'(1);
  assign due = (tally_inc >= period_q) || (period_q == '0);

  assign old_sig = row_sig_q[way_q*SigBits +: SigBits];

  // victim search: age so the largest rrpv reaches three
  logic [1:0]         top;
  logic [2*Ways-1:0]  aged;
  logic [WayBits-1:0] vic;
  always_comb begin
    top = 2'd0;
    for (int w = 0; w < Ways; w++)
      if (row_rrpv_q[2*w +: 2] > top) top = row_rrpv_q[2*w +: 2];
    vic = '0;
    for (int w = Ways-1; w >= 0; w--) begin
      aged[2*w +: 2] = row_rrpv_q[2*w +: 2] + (2'd3 - top);
      if (aged[2*w +: 2] == 2'd3) vic = WayBits'(w);
    end
  end

  logic bip_lead, lip_lead, use_bip, coin;
  logic [15:0] lfsr_adv;
  logic [1:0]  ins;
  assign bip_lead = AllBip || (set_q >= SetBits'(BipFirst));
  assign lip_lead = !bip_lead && (set_q < SetBits'(LeaderSets));
  assign use_bip  = !lip_lead && (bip_lead || duel_q < DuelMid);
  assign lfsr_adv = lfsr_next(lfsr_q);
  assign coin     = lfsr_adv[4:0] == 5'd0;

  always_comb begin
    ins = (use_bip && coin) ? RrpvNear : RrpvDistant;
    if (hot) ins = RrpvNear;
  end

  logic upd_miss;
  assign upd_miss = (state_q == StSig) && kind_q == KindUpdate && !hit_q;
  assign sig_inc  = (state_q == StSig) && kind_q == KindUpdate && hit_q;
  assign sig_dec  = upd_miss && old_sig != '0;
  assign sig_decay = upd_miss && conf_new_q < 2'd2 && due_q;

  rrip_sig_table #(.SigBits(SigBits)) u_sig (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .old_sig_i(old_sig),
    .inc_i    (sig_inc),
    .dec_i    (sig_dec),
    .decay_i  (sig_decay),
    .new_sig_i(sig_q),
    .hot_o    (hot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == SetBits'(Sets-1)) state_d = StIdle;
      StIdle:  if (accept) state_d = StRead;
      StRead:  state_d = StSig;
      StSig:   state_d = StOut;
      StOut:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wr_en     = 1'b0;
    wr_set    = set_q;
    wr_rrpv   = row_rrpv_q;
    wr_sig    = row_sig_q;
    wr_conf   = conf_new_q;
    wr_addr   = addr_q;
    wr_stride = stride_new_q;
    tally_d   = tally_q;
    duel_d    = duel_q;
    lfsr_d    = lfsr_q;
    res_d     = res_q;
    unique case (state_q)
      StClear: begin
        wr_en = 1'b1; wr_set = clr_q; wr_rrpv = '1; wr_sig = '0;
        wr_conf = '0; wr_addr = '0; wr_stride = '0;
      end
      StSig: begin
        wr_en = 1'b1;
        res_d = '{bypassed: 1'b0, inserted_rrpv: RrpvDistant, victim_way: '0};
        if (kind_q == KindVictim) begin
          wr_rrpv = aged; wr_conf = rd_conf_hold_q; wr_addr = addr_hold_q;
          wr_stride = stride_hold_q;
          res_d.victim_way = 4'(vic);
        end else begin
          tally_d = due_q ? '0 : tally_inc_q;
          if (hit_q) begin
            wr_rrpv[2*way_q +: 2] = RrpvNear;
            wr_conf = rd_conf_hold_q; wr_addr = addr_hold_q; wr_stride = stride_hold_q;
            res_d.inserted_rrpv = RrpvNear;
          end else begin
            wr_sig[way_q*SigBits +: SigBits] = sig_q;
            if (conf_new_q >= 2'd2) begin
              wr_rrpv[2*way_q +: 2] = RrpvDistant;
              res_d.bypassed = 1'b1;
            end else begin
              wr_rrpv[2*way_q +: 2] = ins;
              res_d.inserted_rrpv = ins;
              if (use_bip) lfsr_d = lfsr_adv;
              if (lip_lead && duel_q != '0) duel_d = duel_q - DuelWidth'(1);
              else if (bip_lead && duel_q != DuelMax) duel_d = duel_q + DuelWidth'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser;
      set_q  <= SetBits'(s_axis_tdata[10:0]);
      way_q  <= WayBits'(s_axis_tdata[14:11]);
      addr_q <= s_axis_tdata[78:15];
      sig_q  <= sig_in;
      hit_q  <= s_axis_tdata[97];
    end
    if (state_q == StRead) begin
      row_rrpv_q     <= rd_rrpv;
      row_sig_q      <= rd_sig;
      rd_conf_hold_q <= rd_conf;
      addr_hold_q    <= rd_addr;
      stride_hold_q  <= rd_stride;
      conf_new_q     <= conf_new;
      stride_new_q   <= delta;
      due_q          <= due;
      tally_inc_q    <= tally_inc;
    end
    res_q <= res_d;
    // hand the result over once the output register is free
    if (state_q == StOut && out_free) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      period_q <= PeriodReset;
      tally_q  <= '0;
      duel_q   <= DuelMid;
      lfsr_q   <= LfsrReset;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + SetBits'(1);
      if (cfg_we_i) period_q <= cfg_wdata_i;
      tally_q <= tally_d;
      duel_q  <= duel_d;
      lfsr_q  <= lfsr_d;
      if (state_q == StOut) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, out_q};

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StRead)
    else $error("accept did not start an access");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> !s_axis_tready)
    else $error("item taken during clearing pass");
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == StOut)
    else $error("result without item");
  a_victim_rrpv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut && kind_q == KindVictim |-> res_q.inserted_rrpv == RrpvDistant)
    else $error("victim result rrpv wrong");
`endif
endmodule

// ===== tb/sv/rrip_ship_stream_dueling_policy_tb.sv =====
// testbench for the ship rrip replacement policy: random and directed items checked against a predictor
module rrip_ship_stream_dueling_policy_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrip_pkg::*;

  localparam int unsigned NSets = 2048;
  localparam int unsigned NWays = 16;
  localparam int unsigned NLead = 32;
  localparam int unsigned DuelMid = 512;
  localparam int unsigned DuelMax = 1023;
  localparam int unsigned StallLimit = 20000;

  // one request item as seen on the input stream
  typedef struct {
    logic            kind;
    logic [SetW-1:0] set_idx;
    logic [WayW-1:0] way;
    logic [AddrW-1:0] addr;
    logic [PcW-1:0]  pc;
    logic            hit;
  } req_t;

  // replacement state mirror and queue of expected result items
  class rrip_scoreboard;
    logic [1:0]       rrpv [NSets][NWays];
    logic [5:0]       sigs [NSets][NWays];
    logic [1:0]       ctr [64];
    logic [1:0]       conf [NSets];
    logic [AddrW-1:0] prev_addr [NSets];
    logic [AddrW-1:0] last_stride [NSets];
    logic [9:0]       duel;
    logic [19:0]      tally;
    logic [15:0]      lfsr;
    logic [19:0]      period;
    rrip_res_t        pending [$];
    int               errors;

    function void clear();
      for (int s = 0; s < NSets; s++) begin
        for (int w = 0; w < NWays; w++) begin
          rrpv[s][w] = RrpvDistant;
          sigs[s][w] = '0;
        end
        conf[s] = '0;
        prev_addr[s] = '0;
        last_stride[s] = '0;
      end
      for (int i = 0; i < 64; i++) ctr[i] = 2'd1;
      duel = DuelMid;
      tally = '0;
      lfsr = LfsrReset;
      period = PeriodReset;
      errors = 0;
      pending.delete();
    endfunction

    // work out the result of one accepted request and advance the mirror
    function void note_request(req_t r);
      rrip_res_t res;
      int s, w, top;
      logic due, bip_lead, lip_lead, fb;
      logic [5:0] sg, old;
      logic [1:0] ins;
      logic [AddrW-1:0] d;
      s = r.set_idx;
      w = r.way;
      res = '0;
      if (r.kind == KindVictim) begin
        top = 0;
        for (int i = 0; i < NWays; i++) if (rrpv[s][i] > top) top = rrpv[s][i];
        for (int i = 0; i < NWays; i++) rrpv[s][i] = 2'(rrpv[s][i] + (3 - top));
        for (int i = NWays - 1; i >= 0; i--) if (rrpv[s][i] == 2'd3) res.victim_way = 4'(i);
        res.inserted_rrpv = RrpvDistant;
        pending.push_back(res);
        return;
      end
      tally = 20'(tally + 1);
      due = (tally >= period);
      if (due) tally = '0;
      sg = r.pc[5:0] ^ r.pc[11:6] ^ r.pc[17:12];
      old = sigs[s][w];
      if (r.hit) begin
        if (ctr[old] < 3) ctr[old]++;
        rrpv[s][w] = RrpvNear;
        res.inserted_rrpv = RrpvNear;
        pending.push_back(res);
        return;
      end
      // stride detector, a zero previous address counts as none
      d = (prev_addr[s] == 0) ? '0 : r.addr - prev_addr[s];
      if (prev_addr[s] != 0 && d != 0 && d == last_stride[s]) begin
        if (conf[s] < 3) conf[s]++;
      end else if (conf[s] > 0) conf[s]--;
      last_stride[s] = d;
      prev_addr[s] = r.addr;
      if (old != 0 && ctr[old] > 0) ctr[old]--;
      if (conf[s] >= 2) begin
        rrpv[s][w] = RrpvDistant;
        sigs[s][w] = sg;
        res.inserted_rrpv = RrpvDistant;
        res.bypassed = 1'b1;
        pending.push_back(res);
        return;
      end
      bip_lead = (s >= NSets - NLead);
      lip_lead = !bip_lead && s < NLead;
      ins = RrpvDistant;
      if (!lip_lead && (bip_lead || duel < DuelMid)) begin
        fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
        lfsr = {fb, lfsr[15:1]};
        if (lfsr[4:0] == 0) ins = RrpvNear;
      end
      if (ctr[sg] >= 2) ins = RrpvNear;
      rrpv[s][w] = ins;
      sigs[s][w] = sg;
      if (lip_lead) begin
        if (duel > 0) duel--;
      end else if (bip_lead) begin
        if (duel < DuelMax) duel++;
      end
      if (due) for (int i = 0; i < 64; i++) if (ctr[i] > 0) ctr[i]--;
      res.inserted_rrpv = ins;
      pending.push_back(res);
    endfunction

    function void check_result(rrip_res_t got);
      rrip_res_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.victim_way !== exp_res.victim_way) begin
        $display("%0t: victim_way expected %0d actual %0d", $realtime,
                 exp_res.victim_way, got.victim_way);
        errors++;
      end
      if (got.inserted_rrpv !== exp_res.inserted_rrpv) begin
        $display("%0t: inserted_rrpv expected %0d actual %0d", $realtime,
                 exp_res.inserted_rrpv, got.inserted_rrpv);
        errors++;
      end
      if (got.bypassed !== exp_res.bypassed) begin
        $display("%0t: bypassed expected %0d actual %0d", $realtime,
                 exp_res.bypassed, got.bypassed);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [19:0]  cfg_wdata_i = '0;

  rrip_scoreboard policy_sb;
  int  idle_cycles;

  always #1 clk_i = ~clk_i;

  rrip_ship_stream_dueling_policy dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  // mostly short gaps, now and then a long one, sometimes none at all
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random back-pressure, check on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) policy_sb.check_result(m_axis_tdata[6:0]);
  end

  initial begin : sink_stall
    int g;
    forever begin
      @(negedge clk_i);
      g = gap_len();
      m_axis_tready <= (g == 0) ? 1'b1 : 1'b0;
      repeat (g) @(negedge clk_i);
      if (g != 0) m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays up into the next item when there is no gap
  task automatic send_item(req_t r);
    int g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {6'b0, r.hit, r.pc, r.addr, r.way, r.set_idx};
    do @(posedge clk_i); while (!s_axis_tready);
    policy_sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (policy_sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_period(logic [19:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    policy_sb.period = v;
  endtask

  function automatic req_t rand_req(logic [SetW-1:0] s);
    req_t r;
    r.kind = $urandom_range(0, 2) != 0;
    r.set_idx = s;
    r.way = WayW'($urandom_range(0, 15));
    r.addr = {$urandom, $urandom};
    r.pc = PcW'($urandom);
    r.hit = $urandom_range(0, 2) == 0;
    return r;
  endfunction

  // a set from a handful of followers, the two leader ranges or anywhere at random
  function automatic logic [SetW-1:0] pick_set();
    case ($urandom_range(0, 4))
      0: return SetW'($urandom_range(0, NLead - 1));
      1: return SetW'($urandom_range(NSets - NLead, NSets - 1));
      2: return SetW'($urandom);
      default: return SetW'(100 + $urandom_range(0, 7));
    endcase
  endfunction

  initial begin : stimulus
    req_t r;
    logic [SetW-1:0] s;
    logic [AddrW-1:0] a, st;
    int run_len;
    idle_cycles = 0;
    policy_sb = new();
    policy_sb.clear();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass of the row memories after reset is waited out by the handshake

    // directed: field extremes, hit and miss, leaders, a short stream
    r = '{KindVictim, 11'd0, 4'd0, 64'd0, 18'd0, 1'b0};
    send_item(r);
    r = '{KindUpdate, 11'd2047, 4'd15, '1, '1, 1'b0};
    send_item(r);
    r = '{KindUpdate, 11'd2047, 4'd15, '1, '1, 1'b1};
    send_item(r);
    r = '{KindVictim, 11'd2047, 4'd15, '1, '1, 1'b1};
    send_item(r);
    r = '{KindUpdate, 11'd5, 4'd3, 64'h1000, 18'h15555, 1'b0};
    send_item(r);
    r = '{KindUpdate, 11'd500, 4'd7, 64'h2000, 18'h2aaaa, 1'b0};
    send_item(r);
    for (int i = 0; i < 5; i++) begin
      r = '{KindUpdate, 11'd300, 4'(i), 64'h8000 + 64'(i) * 64, 18'h123, 1'b0};
      send_item(r);
    end
    for (int i = 0; i < 4; i++) begin
      r = '{KindVictim, 11'd300, 4'd0, 64'd0, 18'd0, 1'b0};
      send_item(r);
    end

    // decay due on every update, then sweep other periods including both extremes
    write_period(20'd1);
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 90; n++) begin
        s = pick_set();
        if ($urandom_range(0, 3) == 0) begin
          // strided miss run on one set with random base and stride
          a = {$urandom, $urandom};
          st = 64'($urandom_range(1, 4096));
          run_len = $urandom_range(3, 6);
          for (int k = 0; k < run_len; k++) begin
            r = rand_req(s);
            r.kind = KindUpdate;
            r.hit = 1'b0;
            r.addr = a + st * 64'(k);
            send_item(r);
          end
        end else begin
          r = rand_req(s);
          send_item(r);
        end
        if (n == 45) drain();
      end
      case (ph)
        0: write_period(20'd7);
        1: write_period(20'hFFFFF);
        2: write_period(20'd0);
        default: ;
      endcase
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (policy_sb.errors == 0 && policy_sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rrip_pkg.sv
hdl/rrip_sig_table.sv
hdl/rrip_set_mem.sv
hdl/rrip_ship_stream_dueling_policy.sv
tb/sv/rrip_ship_stream_dueling_policy_tb.sv
